/* rtl/bbp_pi_partial_sum_assert.svh */
// ----------------------------------------------------------------------------
// BBP partial sum assertion macros
// Shared property templates for the BBP partial-sum block. Each macro
// expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef BBP_PI_PARTIAL_SUM_ASSERT_SVH
`define BBP_PI_PARTIAL_SUM_ASSERT_SVH

// Same-cycle implication.
`define BBP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BBP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/bbp_pkg.sv */
// ----------------------------------------------------------------------------
// BBP package
// Widths, register indexes, per-division constants and shared types for the
// BBP pi partial-sum block.
// ----------------------------------------------------------------------------
package bbp_pkg;

  // Field widths
  localparam int unsigned TT_W = 16;  // total_terms
  localparam int unsigned WC_W = 9;   // worker_count
  localparam int unsigned WI_W = 8;   // worker_index
  localparam int unsigned QW   = 64;  // quotient / sum width
  localparam int unsigned EW   = 7;   // exponent width (0..64)

  // Configuration register indexes
  localparam logic [0:0] REG_TOTAL_TERMS  = 1'b0;
  localparam logic [0:0] REG_WORKER_COUNT = 1'b1;

  // Per-division divisor offset (8k + c) and exponent offset (F + a)
  localparam logic [2:0] DIV_OFS [4] = '{3'd1, 3'd4, 3'd5, 3'd6};
  localparam logic [1:0] EXP_ADD [4] = '{2'd2, 2'd1, 2'd0, 2'd0};

  // Result of the term split division
  typedef struct packed {
    logic            done;
    logic [TT_W-1:0] quo;
    logic [WC_W-1:0] rem;
  } split_res_t;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_RANGE,
    ST_CHECK,
    ST_DIV,
    ST_DIVW,
    ST_SHIFT,
    ST_DONE
  } state_e;

endpackage

/* rtl/bbp_split_div.sv */
// ----------------------------------------------------------------------------
// BBP term split divider
// Restoring bit-serial divide of total_terms by worker_count, one quotient
// bit per cycle; gives base share and remainder.
// ----------------------------------------------------------------------------
module bbp_split_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bbp_pkg::TT_W-1:0]  dividend_i,
  input  logic [bbp_pkg::WC_W-1:0]  divisor_i,
  output bbp_pkg::split_res_t       res_o
);

  logic                     busy_q, done_q;
  logic [3:0]               cnt_q;
  logic [bbp_pkg::TT_W-1:0] acc_q;   // dividend in, quotient out
  logic [bbp_pkg::WC_W-1:0] rem_q, div_q;
  logic [bbp_pkg::WC_W:0]   trial, diff;
  logic                     ge;

  // One restoring step
  always_comb begin
    trial = {rem_q, acc_q[bbp_pkg::TT_W-1]};
    diff  = trial - {1'b0, div_q};
    ge    = trial >= {1'b0, div_q};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'(bbp_pkg::TT_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 4'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[bbp_pkg::TT_W-2:0], ge};
      rem_q <= ge ? diff[bbp_pkg::WC_W-1:0] : trial[bbp_pkg::WC_W-1:0];
    end
  end

  assign res_o.done = done_q;
  assign res_o.quo  = acc_q;
  assign res_o.rem  = rem_q;

endmodule

/* rtl/bbp_pow2_div.sv */
// ----------------------------------------------------------------------------
// BBP power-of-two divider
// Bit-serial floor(2^e / d) modulo 2^64. The dividend is a single one bit,
// so only a narrow remainder is kept.
// ----------------------------------------------------------------------------
module bbp_pow2_div #(
  parameter int unsigned DW = 7
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [bbp_pkg::EW-1:0]   exp_i,
  input  logic [DW-1:0]            div_i,
  output logic                     done_o,
  output logic [bbp_pkg::QW-1:0]   quo_o
);

  logic                   busy_q, done_q, lead_q;
  logic [bbp_pkg::EW-1:0] cnt_q;
  logic [DW-1:0]          rem_q, div_q;
  logic [bbp_pkg::QW-1:0] quo_q;
  logic [DW:0]            trial, diff;
  logic                   ge;

  // One step: bring in the next dividend bit (one only at the top)
  always_comb begin
    trial = {rem_q, lead_q};
    diff  = trial - {1'b0, div_q};
    ge    = trial >= {1'b0, div_q};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= exp_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - bbp_pkg::EW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath; top quotient bit of 2^64 / 1 falls off the end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      lead_q <= 1'b1;
      div_q  <= div_i;
      quo_q  <= '0;
    end else if (busy_q) begin
      lead_q <= 1'b0;
      rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_q  <= {quo_q[bbp_pkg::QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* rtl/bbp_pi_partial_sum.sv */
// A bad worker index is answered in the cycle after it is accepted; otherwise the
// block splits the terms, finds the worker's range and, per term, runs four
// divisions and a shift by 4k, for at most 16 terms when FRAC_BITS = 62.
// Throughput: one request at a time, the next accepted in the cycle after done_o.
// Reset: total_terms = 16, worker_count = 1; sequencer idle.
// The result is shown for one cycle on done_o; the receiver cannot stall.
// ----------------------------------------------------------------------------
// BBP pi partial sum
// Sums one worker's share of the Bailey-Borwein-Plouffe series in unsigned
// fixed point, using bit-serial dividers for the share split and the terms.
// ----------------------------------------------------------------------------
module bbp_pi_partial_sum #(
  parameter int unsigned FRAC_BITS = 62
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_addr_i,
  input  logic [bbp_pkg::TT_W-1:0]  cfg_wdata_i,
  // request
  input  logic                      start,
  output logic                      busy,
  input  logic [bbp_pkg::WI_W-1:0]  worker_index_i,
  // result
  output logic                      done_o,
  output logic [bbp_pkg::QW-1:0]    partial_sum_o,
  output logic                      bad_index_o
);

  localparam int unsigned LIMIT = (FRAC_BITS + 3) / 4;  // terms with 4k < F
  localparam int unsigned KW    = $clog2(LIMIT);
  localparam int unsigned DW    = KW + 3;
  localparam int unsigned RW    = 25;                   // share range width

  bbp_pkg::state_e          state_q, state_d;
  logic [bbp_pkg::TT_W-1:0] total_q;
  logic [bbp_pkg::WC_W-1:0] wc_q;
  logic [bbp_pkg::WI_W-1:0] w_q;
  logic [RW-1:0]            start_q, stop_q;
  logic [KW:0]              k_q, stopk_q;
  logic [1:0]               j_q;
  logic [KW-1:0]            sh_q;
  logic [bbp_pkg::QW-1:0]   term_q, sum_q;
  logic                     bad_q;

  logic                     accept, idx_bad, split_start, div_start, div_done;
  bbp_pkg::split_res_t      split_res;
  logic [bbp_pkg::QW-1:0]   div_quo;
  logic [DW-1:0]            div_d;
  logic [bbp_pkg::EW-1:0]   div_e;

  logic [23:0]              prod;
  logic                     w_lt_rem;
  logic [bbp_pkg::WC_W-1:0] min_wr;
  logic [16:0]              chunk;
  logic [RW-1:0]            start_d, stop_d, stop_c;
  logic                     empty;
  logic [KW:0]              k_inc;
  logic                     last_term;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= 16'd16;
      wc_q    <= 9'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        bbp_pkg::REG_TOTAL_TERMS:  total_q <= cfg_wdata_i;
        bbp_pkg::REG_WORKER_COUNT: wc_q    <= cfg_wdata_i[bbp_pkg::WC_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept  = start && !busy;
  assign idx_bad = {1'b0, worker_index_i} >= wc_q;

  // Share range: start = w*base + min(w, rem), stop = start + chunk
  always_comb begin
    prod     = 24'(w_q) * 24'(split_res.quo);
    w_lt_rem = {1'b0, w_q} < split_res.rem;
    min_wr   = w_lt_rem ? {1'b0, w_q} : split_res.rem;
    chunk    = 17'(split_res.quo) + 17'(w_lt_rem);
    start_d  = RW'(prod) + RW'(min_wr);
    stop_d   = start_d + RW'(chunk);
    stop_c   = (stop_q > RW'(LIMIT)) ? RW'(LIMIT) : stop_q;
    empty    = start_q >= stop_c;
    k_inc    = k_q + (KW+1)'(1);
    last_term = k_inc == stopk_q;
  end

  // Term divisor 8k + c and exponent F + a
  always_comb begin
    div_d = {k_q[KW-1:0], 3'b000} + DW'(bbp_pkg::DIV_OFS[j_q]);
    div_e = bbp_pkg::EW'(FRAC_BITS) + bbp_pkg::EW'(bbp_pkg::EXP_ADD[j_q]);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bbp_pkg::ST_IDLE: begin
        if (accept) state_d = idx_bad ? bbp_pkg::ST_DONE : bbp_pkg::ST_SPLIT;
      end
      bbp_pkg::ST_SPLIT: begin
        if (split_res.done) state_d = bbp_pkg::ST_RANGE;
      end
      bbp_pkg::ST_RANGE: state_d = bbp_pkg::ST_CHECK;
      bbp_pkg::ST_CHECK: state_d = empty ? bbp_pkg::ST_DONE : bbp_pkg::ST_DIV;
      bbp_pkg::ST_DIV:   state_d = bbp_pkg::ST_DIVW;
      bbp_pkg::ST_DIVW: begin
        if (div_done) state_d = (j_q == 2'd3) ? bbp_pkg::ST_SHIFT : bbp_pkg::ST_DIV;
      end
      bbp_pkg::ST_SHIFT: begin
        if (sh_q == '0) state_d = last_term ? bbp_pkg::ST_DONE : bbp_pkg::ST_DIV;
      end
      bbp_pkg::ST_DONE:  state_d = bbp_pkg::ST_IDLE;
      default:           state_d = bbp_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    busy        = state_q != bbp_pkg::ST_IDLE;
    done_o      = state_q == bbp_pkg::ST_DONE;
    split_start = (state_q == bbp_pkg::ST_IDLE) && accept && !idx_bad;
    div_start   = state_q == bbp_pkg::ST_DIV;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= bbp_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      bbp_pkg::ST_IDLE: begin
        if (accept) begin
          w_q   <= worker_index_i;
          bad_q <= idx_bad;
          sum_q <= '0;
        end
      end
      bbp_pkg::ST_RANGE: begin
        start_q <= start_d;
        stop_q  <= stop_d;
      end
      bbp_pkg::ST_CHECK: begin
        k_q     <= start_q[KW:0];
        stopk_q <= stop_c[KW:0];
        j_q     <= 2'd0;
      end
      bbp_pkg::ST_DIVW: begin
        if (div_done) begin
          term_q <= (j_q == 2'd0) ? div_quo : term_q - div_quo;
          j_q    <= j_q + 2'd1;
          sh_q   <= k_q[KW-1:0];
        end
      end
      bbp_pkg::ST_SHIFT: begin
        // shift right by 4k, one hex digit per cycle, then accumulate
        if (sh_q != '0) begin
          term_q <= {4'b0000, term_q[bbp_pkg::QW-1:4]};
          sh_q   <= sh_q - KW'(1);
        end else begin
          sum_q <= sum_q + term_q;
          k_q   <= k_inc;
          j_q   <= 2'd0;
        end
      end
      default: ;
    endcase
  end

  assign partial_sum_o = sum_q;
  assign bad_index_o   = bad_q;

  // Share split divider
  bbp_split_div u_split (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (split_start),
    .dividend_i (total_q),
    .divisor_i  (wc_q),
    .res_o      (split_res)
  );

  // Term quotient divider
  bbp_pow2_div #(
    .DW (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .exp_i   (div_e),
    .div_i   (div_d),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Assertions
  `include "bbp_pi_partial_sum_assert.svh"

  `BBP_ASSERT_IMP(a_bad_zero, done_o && bad_index_o, partial_sum_o == '0, "bad index with nonzero sum")
  `BBP_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `BBP_ASSERT_IMP(a_div_done_st, div_done, state_q == bbp_pkg::ST_DIVW, "term quotient outside wait")
  `BBP_ASSERT_IMP(a_split_done_st, split_res.done, state_q == bbp_pkg::ST_SPLIT, "split done outside wait")

endmodule

/* tb/bbp_sum_checker.sv */
// ----------------------------------------------------------------------------
// BBP partial sum checker
// Watches the register port and the request and result channels of the BBP
// partial-sum block. Predicts each worker's fixed-point partial sum from its
// own copy of the registers and compares every result field against the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bbp_sum_checker #(
  parameter int unsigned FRAC_BITS = 62
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // register port
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_addr_i,
  input  logic [bbp_pkg::TT_W-1:0]  cfg_wdata_i,
  // request channel
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic [bbp_pkg::WI_W-1:0]  worker_index_i,
  // result channel
  input  logic                      done_i,
  input  logic [bbp_pkg::QW-1:0]    partial_sum_i,
  input  logic                      bad_index_i,
  // status to the test top
  output int unsigned               mismatch_count_o,
  output int unsigned               pending_o,
  output int unsigned               checked_o,
  output int unsigned               bad_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import bbp_pkg::*;

  typedef struct packed {
    logic [QW-1:0] sum;
    logic          bad;
  } share_sum_t;

  // local copy of the registers
  logic [TT_W-1:0] total_terms_q;
  logic [WC_W-1:0] worker_count_q;

  // predicted sums, oldest first
  share_sum_t share_sums_q[$];

  // floor(2^e / d), kept to 64 bits (2^64 / 1 wraps to zero)
  function automatic logic [QW-1:0] pow2_div(input int unsigned e, input logic [QW-1:0] d);
    logic [QW:0] num;
    num = (QW+1)'(1) << e;
    return QW'(num / {1'b0, d});
  endfunction

  // one series term in fixed point, already scaled by 16^-k
  function automatic logic [QW-1:0] series_term(input longint unsigned k);
    logic [QW-1:0] b;
    logic [QW-1:0] t;
    b = QW'(8 * k);
    t = pow2_div(FRAC_BITS + 2, b + 1) - pow2_div(FRAC_BITS + 1, b + 4)
      - pow2_div(FRAC_BITS, b + 5) - pow2_div(FRAC_BITS, b + 6);
    return t >> (4 * k);
  endfunction

  // expected result for one worker under the given register values
  function automatic share_sum_t worker_partial_sum(input logic [WI_W-1:0] w,
                                                    input logic [TT_W-1:0] tt,
                                                    input logic [WC_W-1:0] wc);
    share_sum_t       res;
    longint unsigned  base, rem, chunk, first, stop, lim, k;
    res.sum = '0;
    res.bad = 1'b0;
    if (w >= wc) begin
      res.bad = 1'b1;
      return res;
    end
    base  = tt / wc;
    rem   = tt % wc;
    chunk = base + ((w < rem) ? 1 : 0);
    first = w * base + ((w < rem) ? w : rem);
    stop  = first + chunk;
    // terms with 4k >= FRAC_BITS vanish
    lim = (FRAC_BITS + 3) / 4;
    if (stop > lim) stop = lim;
    for (k = first; k < stop; k++) res.sum += series_term(k);
    return res;
  endfunction

  // track registers, predict on each accepted request, check each result
  always @(posedge clk_i or negedge rst_ni) begin
    share_sum_t want;
    if (!rst_ni) begin
      total_terms_q    <= TT_W'(16);
      worker_count_q   <= WC_W'(1);
      share_sums_q.delete();
      pending_o        <= 0;
      mismatch_count_o = 0;
      checked_o        = 0;
      bad_seen_o       = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_TOTAL_TERMS) total_terms_q <= cfg_wdata_i;
        else if (cfg_addr_i == REG_WORKER_COUNT) worker_count_q <= cfg_wdata_i[WC_W-1:0];
      end
      if (start_i && !busy_i) begin
        share_sums_q.push_back(worker_partial_sum(worker_index_i, total_terms_q,
                                                  worker_count_q));
      end
      if (done_i) begin
        if (share_sums_q.size() == 0) begin
          if (mismatch_count_o < 10)
            $display("%0t: result with no request outstanding: sum=%h bad=%b",
                     $realtime, partial_sum_i, bad_index_i);
          mismatch_count_o++;
        end else begin
          want = share_sums_q.pop_front();
          checked_o++;
          if (bad_index_i) bad_seen_o++;
          if (partial_sum_i !== want.sum) begin
            if (mismatch_count_o < 10)
              $display("%0t: partial_sum mismatch: expected %h, got %h",
                       $realtime, want.sum, partial_sum_i);
            mismatch_count_o++;
          end
          if (bad_index_i !== want.bad) begin
            if (mismatch_count_o < 10)
              $display("%0t: bad_index mismatch: expected %b, got %b",
                       $realtime, want.bad, bad_index_i);
            mismatch_count_o++;
          end
        end
      end
      pending_o <= share_sums_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// BBP partial sum testbench top
// Drives register settings and worker-index requests into the BBP partial-sum
// block, with random pacing in most phases, then reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bbp_pkg::*;

  localparam int unsigned FRAC_BITS  = 62;
  localparam int unsigned N_PHASES   = 7;
  localparam int unsigned PHASE_REQS = 17;
  localparam int unsigned TAIL_WAIT  = 5000;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [0:0]      cfg_addr_i;
  logic [TT_W-1:0] cfg_wdata_i;
  logic            start;
  logic            busy;
  logic [WI_W-1:0] worker_index_i;
  logic            done_o;
  logic [QW-1:0]   partial_sum_o;
  logic            bad_index_o;

  int unsigned mismatches, pending, checked, bad_seen;
  int unsigned n_sent, n_settings;
  bit          pace_on;

  bbp_pi_partial_sum #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .worker_index_i (worker_index_i),
    .done_o         (done_o),
    .partial_sum_o  (partial_sum_o),
    .bad_index_o    (bad_index_o)
  );

  bbp_sum_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start),
    .busy_i           (busy),
    .worker_index_i   (worker_index_i),
    .done_i           (done_o),
    .partial_sum_i    (partial_sum_o),
    .bad_index_i      (bad_index_o),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .checked_o        (checked),
    .bad_seen_o       (bad_seen)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // watchdog
  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // one request; start stays high across back-to-back requests
  task automatic send_request(input logic [WI_W-1:0] w);
    int unsigned gap;
    gap = pace_on ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    worker_index_i <= w;
    do @(posedge clk_i); while (busy);
    n_sent++;
  endtask

  // hold off until every predicted result has come back
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write both registers; spare upper bits of worker_count data are junk
  task automatic set_config(input logic [TT_W-1:0] tt, input logic [WC_W-1:0] wc);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_TOTAL_TERMS;
    cfg_wdata_i <= tt;
    @(posedge clk_i);
    cfg_addr_i  <= REG_WORKER_COUNT;
    cfg_wdata_i <= {TT_W'($urandom_range(0, 127)) << WC_W} | TT_W'(wc);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    n_settings++;
  endtask

  // stimulus
  initial begin
    logic [TT_W-1:0] tt;
    logic [WC_W-1:0] wc;
    int unsigned     top_w;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_addr_i     = REG_TOTAL_TERMS;
    cfg_wdata_i    = '0;
    start          = 1'b0;
    worker_index_i = '0;
    n_sent         = 0;
    n_settings     = 1;
    pace_on        = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: one worker holding all sixteen terms, term zero included
    send_request(8'd0);
    send_request(8'd255);
    send_request(8'd1);
    wait_idle();
    // no terms at all
    set_config(16'd0, 9'd4);
    send_request(8'd0);
    send_request(8'd3);
    send_request(8'd4);
    wait_idle();
    // no workers: every index is bad
    set_config(16'd16, 9'd0);
    send_request(8'd0);
    send_request(8'd128);
    wait_idle();
    // more workers than terms
    set_config(16'd3, 9'd8);
    send_request(8'd2);
    send_request(8'd3);
    send_request(8'd7);
    send_request(8'd8);
    wait_idle();
    // largest total_terms with 256 workers; far terms drop out
    set_config(16'hFFFF, 9'd256);
    send_request(8'd0);
    send_request(8'd255);
    send_request(8'd15);
    wait_idle();
    // uneven split, straddling the far-term limit
    set_config(16'd17, 9'd5);
    send_request(8'd0);
    send_request(8'd1);
    send_request(8'd2);
    send_request(8'd4);
    wait_idle();
    set_config(16'd1, 9'd1);
    send_request(8'd0);
    wait_idle();

    // random settings, mostly small, with occasional extremes
    for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
      case ($urandom_range(0, 9))
        0:       tt = 16'hFFFF;
        1:       tt = TT_W'($urandom);
        2:       tt = '0;
        default: tt = TT_W'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 9))
        0:       wc = 9'd256;
        1:       wc = 9'd511;
        2:       wc = '0;
        default: wc = WC_W'($urandom_range(1, 20));
      endcase
      top_w   = (wc > 255) ? 255 : wc;
      pace_on = (ph % 3) != 2;
      set_config(tt, wc);
      for (int unsigned i = 0; i < PHASE_REQS; i++) begin
        if ($urandom_range(0, 3) != 0) send_request(WI_W'($urandom_range(0, top_w)));
        else send_request(WI_W'($urandom_range(0, 255)));
      end
      wait_idle();
    end

    // catch any stray late result
    repeat (TAIL_WAIT) @(posedge clk_i);
    $display("Sent %0d requests across %0d register settings.", n_sent, n_settings);
    $display("Checked %0d results, %0d of them flagged as bad worker index.",
             checked, bad_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
